>>> rtl/swtq_pkg.sv
package swtq_pkg;

	localparam int ENTRIES_DEF = 16;
	localparam int MAX_RESULTS = 16;
	localparam int TIME_W = 32;
	localparam int TAG_W = 8;
	localparam int DELAY_W = 16;
	localparam logic [TIME_W-1:0] SAT_TIME = 32'hFFFF_FFFE;
	localparam logic [TIME_W-1:0] TPS_RESET = 32'd1000000;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	typedef enum logic [2:0] {
		STAT_INSERTED = 3'd0,
		STAT_REJ_NEG = 3'd1,
		STAT_REJ_FULL = 3'd2,
		STAT_WOKEN = 3'd3,
		STAT_IDLE = 3'd4
	} status_t;

	typedef struct packed {
		logic action;
		logic [TIME_W-1:0] now_time;
		logic signed [DELAY_W-1:0] delay_seconds;
		logic [TAG_W-1:0] owner_tag;
	} in_item_t;

	typedef struct packed {
		status_t status;
		logic [TAG_W-1:0] woken_tag;
		logic last;
	} out_item_t;

	typedef struct packed {
		logic [TIME_W-1:0] wake;
		logic [TAG_W-1:0] tag;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_ADD,
		S_INS_RD,
		S_INS_CMP,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_SCAN_END,
		S_POP_RD,
		S_POP_EMIT,
		S_EMIT
	} state_t;

endpackage

>>> rtl/swtq_ram.sv
module swtq_ram #(
	parameter int DEPTH = swtq_pkg::ENTRIES_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input swtq_pkg::entry_t wdata,
	input logic re,
	input logic [AW-1:0] raddr,
	output swtq_pkg::entry_t rdata
);

	swtq_pkg::entry_t mem_q [DEPTH];
	swtq_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read data holds until the next read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/swtq_wake_calc.sv
module swtq_wake_calc (
	input logic clk,
	input logic [swtq_pkg::TIME_W-1:0] now_time,
	input logic [swtq_pkg::DELAY_W-2:0] delay_mag,
	input logic [swtq_pkg::TIME_W-1:0] ticks_per_second,
	output logic [swtq_pkg::TIME_W-1:0] wake_time
);

	localparam int PW = swtq_pkg::TIME_W + swtq_pkg::DELAY_W - 1;

	logic [PW-1:0] prod_s1;
	logic [swtq_pkg::TIME_W-1:0] now_s1;
	logic [PW:0] sum;
	logic [swtq_pkg::TIME_W-1:0] wake_s2;

	assign sum = {1'b0, prod_s1} + (PW+1)'(now_s1);

	always_ff @(posedge clk) begin
		prod_s1 <= PW'(delay_mag) * PW'(ticks_per_second);
		now_s1 <= now_time;
	end

	// The all-ones time is never stored, so the sum saturates one below it.
	always_ff @(posedge clk) begin
		if (sum > (PW+1)'(swtq_pkg::SAT_TIME)) begin
			wake_s2 <= swtq_pkg::SAT_TIME;
		end else begin
			wake_s2 <= sum[swtq_pkg::TIME_W-1:0];
		end
	end

	assign wake_time = wake_s2;

endmodule

>>> rtl/sorted_wakeup_timer_queue.sv
// Sorted wakeup timer queue. Holds up to ENTRIES sleep requests in a ring buffer kept in
// ascending wake-time order; a new entry goes ahead of entries with an equal wake time. An
// insert computes now_time + delay_seconds * ticks_per_second (saturated at 0xFFFFFFFE) and
// returns one result; a tick returns the tags of every due head entry, up to 16, with last
// set on the final one, or a single "nothing due" result. One item is processed at a time,
// and in_stall is high while it is in progress. The memory has one registered read port, so
// each step of the walk issues a read and then uses the returned entry: an insert moves up
// each entry that sorts after the new one, and a tick scans the due head entries and then
// reads each again to report it, waiting while the output stalls. A rejected insert goes
// straight to its result. The store needs no clearing pass after reset: only slots below the
// entry count are ever read. ticks_per_second may be written through the configuration port
// at any time the block is idle; cfg_ready is always high.
module sorted_wakeup_timer_queue #(
	parameter int ENTRIES = swtq_pkg::ENTRIES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input swtq_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output swtq_pkg::out_item_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [swtq_pkg::TIME_W-1:0] cfg_data
);

	localparam int AW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);

	swtq_pkg::state_t state_q, state_d;
	swtq_pkg::in_item_t item_q, item_d;
	swtq_pkg::status_t res_q, res_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] idx_q, idx_d;
	logic [CW-1:0] n_q, n_d;
	logic [AW-1:0] head_q, head_d;
	logic [swtq_pkg::TIME_W-1:0] tps_q;

	logic out_valid_q;
	swtq_pkg::out_item_t out_q, out_d;
	logic out_load;
	logic out_free;

	logic ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	swtq_pkg::entry_t ram_wdata, ram_rdata, new_entry;

	logic [swtq_pkg::TIME_W-1:0] wake_time;
	logic [swtq_pkg::TIME_W-1:0] cmp_a, cmp_b;
	logic cmp_le;

	function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] lg);
		logic [CW:0] s;
		s = (CW+1)'(head) + (CW+1)'(lg);
		if (s >= (CW+1)'(ENTRIES)) begin
			s = s - (CW+1)'(ENTRIES);
		end
		return s[AW-1:0];
	endfunction

	swtq_wake_calc u_calc (
		.clk (clk),
		.now_time (item_q.now_time),
		.delay_mag (item_q.delay_seconds[swtq_pkg::DELAY_W-2:0]),
		.ticks_per_second (tps_q),
		.wake_time (wake_time)
	);

	swtq_ram #(.DEPTH(ENTRIES)) u_ram (
		.clk (clk),
		.we (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// One comparator serves both walks: an insert shifts an entry up while the new wake
	// time is at or before it, and a tick counts entries due at or before now_time.
	always_comb begin
		if (item_q.action == swtq_pkg::ACT_INSERT) begin
			cmp_a = wake_time;
			cmp_b = ram_rdata.wake;
		end else begin
			cmp_a = ram_rdata.wake;
			cmp_b = item_q.now_time;
		end
	end
	assign cmp_le = cmp_a <= cmp_b;

	assign new_entry.wake = wake_time;
	assign new_entry.tag = item_q.owner_tag;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		item_d = item_q;
		res_d = res_q;
		count_d = count_q;
		idx_d = idx_q;
		n_d = n_q;
		head_d = head_q;
		in_stall = 1'b1;
		out_load = 1'b0;
		out_d.status = res_q;
		out_d.woken_tag = '0;
		out_d.last = 1'b1;
		ram_we = 1'b0;
		ram_waddr = phys(head_q, idx_q);
		ram_wdata = new_entry;
		ram_re = 1'b0;
		ram_raddr = phys(head_q, idx_q);
		unique case (state_q)
			swtq_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					item_d = in_data;
					if (in_data.action == swtq_pkg::ACT_INSERT) begin
						priority if (in_data.delay_seconds[swtq_pkg::DELAY_W-1]) begin
							res_d = swtq_pkg::STAT_REJ_NEG;
							state_d = swtq_pkg::S_EMIT;
						end else if (count_q == CW'(ENTRIES)) begin
							res_d = swtq_pkg::STAT_REJ_FULL;
							state_d = swtq_pkg::S_EMIT;
						end else begin
							state_d = swtq_pkg::S_MUL;
						end
					end else begin
						n_d = '0;
						state_d = swtq_pkg::S_SCAN_RD;
					end
				end
			end
			swtq_pkg::S_MUL: begin
				state_d = swtq_pkg::S_ADD;
			end
			swtq_pkg::S_ADD: begin
				idx_d = count_q;
				state_d = swtq_pkg::S_INS_RD;
			end
			swtq_pkg::S_INS_RD: begin
				if (idx_q == '0) begin
					ram_we = 1'b1;
					count_d = count_q + 1'b1;
					res_d = swtq_pkg::STAT_INSERTED;
					state_d = swtq_pkg::S_EMIT;
				end else begin
					ram_re = 1'b1;
					ram_raddr = phys(head_q, idx_q - 1'b1);
					state_d = swtq_pkg::S_INS_CMP;
				end
			end
			swtq_pkg::S_INS_CMP: begin
				ram_we = 1'b1;
				if (cmp_le) begin
					ram_wdata = ram_rdata;
					idx_d = idx_q - 1'b1;
					state_d = swtq_pkg::S_INS_RD;
				end else begin
					count_d = count_q + 1'b1;
					res_d = swtq_pkg::STAT_INSERTED;
					state_d = swtq_pkg::S_EMIT;
				end
			end
			swtq_pkg::S_SCAN_RD: begin
				if (n_q == count_q || 32'(n_q) == swtq_pkg::MAX_RESULTS) begin
					state_d = swtq_pkg::S_SCAN_END;
				end else begin
					ram_re = 1'b1;
					ram_raddr = phys(head_q, n_q);
					state_d = swtq_pkg::S_SCAN_CMP;
				end
			end
			swtq_pkg::S_SCAN_CMP: begin
				if (cmp_le) begin
					n_d = n_q + 1'b1;
					state_d = swtq_pkg::S_SCAN_RD;
				end else begin
					state_d = swtq_pkg::S_SCAN_END;
				end
			end
			swtq_pkg::S_SCAN_END: begin
				if (n_q == '0) begin
					res_d = swtq_pkg::STAT_IDLE;
					state_d = swtq_pkg::S_EMIT;
				end else begin
					idx_d = '0;
					state_d = swtq_pkg::S_POP_RD;
				end
			end
			swtq_pkg::S_POP_RD: begin
				ram_re = 1'b1;
				state_d = swtq_pkg::S_POP_EMIT;
			end
			swtq_pkg::S_POP_EMIT: begin
				out_d.status = swtq_pkg::STAT_WOKEN;
				out_d.woken_tag = ram_rdata.tag;
				out_d.last = (idx_q + 1'b1) == n_q;
				if (out_free) begin
					out_load = 1'b1;
					if (out_d.last) begin
						head_d = phys(head_q, n_q);
						count_d = count_q - n_q;
						state_d = swtq_pkg::S_IDLE;
					end else begin
						idx_d = idx_q + 1'b1;
						state_d = swtq_pkg::S_POP_RD;
					end
				end
			end
			swtq_pkg::S_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d = swtq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = swtq_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swtq_pkg::S_IDLE;
			count_q <= '0;
			head_q <= '0;
			out_valid_q <= 1'b0;
			tps_q <= swtq_pkg::TPS_RESET;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			head_q <= head_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				tps_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		item_q <= item_d;
		res_q <= res_d;
		idx_q <= idx_d;
		n_q <= n_d;
		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign cfg_ready = 1'b1;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(ENTRIES))
		else $error("entry count exceeds capacity");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(head_q) < ENTRIES)
		else $error("head pointer out of range");

	a_done_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != swtq_pkg::S_IDLE ##1 state_q == swtq_pkg::S_IDLE) |-> out_valid_q)
		else $error("transaction finished without a result");

	a_grow_on_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
			($past(state_q) == swtq_pkg::S_INS_RD || $past(state_q) == swtq_pkg::S_INS_CMP
			|| $past(state_q) == swtq_pkg::S_POP_EMIT))
		else $error("entry count changed outside insert or removal");

	a_reject_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && in_data.action == swtq_pkg::ACT_INSERT
			&& in_data.delay_seconds[swtq_pkg::DELAY_W-1]) |=> count_q == $past(count_q))
		else $error("rejected insert changed the queue");

endmodule
